### rtl/lsst_pkg.sv
package lsst_pkg;

   localparam int MODE_W   = 2;
   localparam int KEY_W    = 16;
   localparam int DUR_W    = 32;
   localparam int TICK_W   = 32;
   localparam int SLOT_W   = 5;
   localparam int TOT_W    = 48;
   localparam int CNT_W    = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_RECORD    = 2'd0,
      MODE_READ_SECT = 2'd1,
      MODE_READ_TOP  = 2'd2,
      MODE_CLEAR     = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INVALID  = 3'd0,
      STAT_NEW      = 3'd1,
      STAT_EXISTING = 3'd2,
      STAT_DROPPED  = 3'd3,
      STAT_READOUT  = 3'd4
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  section_key;
      logic [DUR_W-1:0]  duration;
      logic              duration_valid;
      logic [TICK_W-1:0] sample_tick;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                entry_valid;
      logic [KEY_W-1:0]    entry_key;
      logic [DUR_W-1:0]    min_duration;
      logic [DUR_W-1:0]    max_duration;
      logic [TOT_W-1:0]    total_duration;
      logic [CNT_W-1:0]    section_samples;
      logic [DUR_W-1:0]    top_duration;
      logic [TICK_W-1:0]   top_tick;
      logic [CNT_W-1:0]    total_samples;
      logic [CNT_W-1:0]    dropped_samples;
      logic [CNT_W-1:0]    invalid_samples;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [DUR_W-1:0] min;
      logic [DUR_W-1:0] max;
      logic [TOT_W-1:0] total;
      logic [CNT_W-1:0] count;
   } sect_entry_type;

   typedef struct packed {
      logic             fire;
      logic             found;
      logic [KEY_W-1:0] key;
      logic [DUR_W-1:0] dur;
   } sect_cmd_type;

   typedef struct packed {
      logic [DUR_W-1:0]  dur;
      logic [KEY_W-1:0]  key;
      logic [TICK_W-1:0] tick;
   } top_entry_type;

   typedef struct packed {
      logic          fire;
      top_entry_type entry;
   } top_cmd_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

### rtl/lsst_if.sv
interface lsst_req_if;
   logic                       valid;
   logic                       ready;
   logic [lsst_pkg::MODE_W-1:0] mode;
   logic [lsst_pkg::KEY_W-1:0]  section_key;
   logic [lsst_pkg::DUR_W-1:0]  duration;
   logic                        duration_valid;
   logic [lsst_pkg::TICK_W-1:0] sample_tick;
   logic [lsst_pkg::SLOT_W-1:0] slot_index;

   modport source (output valid, mode, section_key, duration, duration_valid,
                   sample_tick, slot_index, input ready);
   modport sink (input valid, mode, section_key, duration, duration_valid,
                 sample_tick, slot_index, output ready);
endinterface

interface lsst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lsst_pkg::STATUS_W-1:0] status;
   logic                          entry_valid;
   logic [lsst_pkg::KEY_W-1:0]    entry_key;
   logic [lsst_pkg::DUR_W-1:0]    min_duration;
   logic [lsst_pkg::DUR_W-1:0]    max_duration;
   logic [lsst_pkg::TOT_W-1:0]    total_duration;
   logic [lsst_pkg::CNT_W-1:0]    section_samples;
   logic [lsst_pkg::DUR_W-1:0]    top_duration;
   logic [lsst_pkg::TICK_W-1:0]   top_tick;
   logic [lsst_pkg::CNT_W-1:0]    total_samples;
   logic [lsst_pkg::CNT_W-1:0]    dropped_samples;
   logic [lsst_pkg::CNT_W-1:0]    invalid_samples;

   modport source (output valid, status, entry_valid, entry_key, min_duration,
                   max_duration, total_duration, section_samples, top_duration,
                   top_tick, total_samples, dropped_samples, invalid_samples,
                   input ready);
   modport sink (input valid, status, entry_valid, entry_key, min_duration,
                 max_duration, total_duration, section_samples, top_duration,
                 top_tick, total_samples, dropped_samples, invalid_samples,
                 output ready);
endinterface

### rtl/lsst_sect_cell.sv
module lsst_sect_cell (
   input  logic                     clock,
   input  lsst_pkg::sect_cmd_type   cmd,
   input  logic                     live,
   input  logic                     next,
   output logic                     match,
   output lsst_pkg::sect_entry_type entry
);

   lsst_pkg::sect_entry_type entry_ff;
   lsst_pkg::sect_entry_type entry_in;
   logic [lsst_pkg::TOT_W:0] sum;

   assign match = live && (entry_ff.key == cmd.key);
   assign entry = entry_ff;
   assign sum   = {1'b0, entry_ff.total} + (lsst_pkg::TOT_W+1)'(cmd.dur);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.fire && match) begin
         if (cmd.dur < entry_ff.min) entry_in.min = cmd.dur;
         if (cmd.dur > entry_ff.max) entry_in.max = cmd.dur;
         entry_in.total = sum[lsst_pkg::TOT_W] ? '1 : sum[lsst_pkg::TOT_W-1:0];
         entry_in.count = lsst_pkg::sat_inc(entry_ff.count);
      end else if (cmd.fire && next && !cmd.found) begin
         entry_in.key   = cmd.key;
         entry_in.min   = cmd.dur;
         entry_in.max   = cmd.dur;
         entry_in.total = lsst_pkg::TOT_W'(cmd.dur);
         entry_in.count = lsst_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### rtl/lsst_top_cell.sv
module lsst_top_cell (
   input  logic                    clock,
   input  lsst_pkg::top_cmd_type   cmd,
   input  logic                    live,
   input  logic                    prev_ge,
   input  lsst_pkg::top_entry_type prev_entry,
   output logic                    ge,
   output lsst_pkg::top_entry_type entry
);

   lsst_pkg::top_entry_type entry_ff;
   lsst_pkg::top_entry_type entry_in;

   assign ge    = live && (entry_ff.dur >= cmd.entry.dur);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.fire && !ge) begin
         entry_in = prev_ge ? cmd.entry : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### rtl/latency_section_stats_topk.sv
// channel  | dir | handshake   | word
// req_bus  | in  | valid/ready | mode, key, duration, valid flag, tick, slot
// rsp_bus  | out | valid/ready | status, section or top entry, counters
//
// Each word passes ST_IDLE, which registers the request, then ST_EXEC, where
// every section cell compares its key and the top cells shift in parallel.
// The result sits in an output register; a new request is taken while it waits.
// A stalled result holds the block in its execute cycle until it can be moved.
// Synchronous reset empties both tables and zeroes the counters at once.
module latency_section_stats_topk #(
   parameter int SECTION_SLOTS = 32,
   parameter int TOP_SLOTS     = 10
) (
   input logic          clock,
   input logic          reset,
   lsst_req_if.sink     req_bus,
   lsst_rsp_if.source   rsp_bus
);

   localparam int SU_W  = $clog2(SECTION_SLOTS + 1);
   localparam int TU_W  = $clog2(TOP_SLOTS + 1);
   localparam int SSEL_W = (SU_W > lsst_pkg::SLOT_W) ? SU_W : lsst_pkg::SLOT_W;
   localparam int TSEL_W = (TU_W > lsst_pkg::SLOT_W) ? TU_W : lsst_pkg::SLOT_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type                    state_ff, state_in;
   lsst_pkg::req_type            req_ff, req_in;
   lsst_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SU_W-1:0]              sect_used_ff, sect_used_in;
   logic [TU_W-1:0]              top_used_ff, top_used_in;
   logic [lsst_pkg::CNT_W-1:0]   sample_ctr_ff, sample_ctr_in;
   logic [lsst_pkg::CNT_W-1:0]   drop_ctr_ff, drop_ctr_in;
   logic [lsst_pkg::CNT_W-1:0]   invalid_ctr_ff, invalid_ctr_in;

   lsst_pkg::sect_cmd_type       sect_cmd;
   lsst_pkg::top_cmd_type        top_cmd;
   lsst_pkg::sect_entry_type     sect_entries [SECTION_SLOTS];
   lsst_pkg::top_entry_type      top_entries [TOP_SLOTS];
   logic [SECTION_SLOTS-1:0]     sect_live, sect_next, sect_match;
   logic [TOP_SLOTS-1:0]         top_live, top_ge;
   logic                         found, exec_fire, out_free;
   lsst_pkg::mode_type           mode;
   lsst_pkg::sect_entry_type     sect_rd;
   lsst_pkg::top_entry_type      top_rd;
   logic                         sect_rd_ok, top_rd_ok;

   assign mode      = lsst_pkg::mode_type'(req_ff.mode);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign exec_fire = (state_ff == ST_EXEC) && out_free;
   assign found     = |sect_match;
   assign req_bus.ready = (state_ff == ST_IDLE);

   assign req_in = '{mode: req_bus.mode, section_key: req_bus.section_key,
                     duration: req_bus.duration,
                     duration_valid: req_bus.duration_valid,
                     sample_tick: req_bus.sample_tick, slot_index: req_bus.slot_index};

   assign sect_cmd.fire  = exec_fire && (mode == lsst_pkg::MODE_RECORD)
                           && req_ff.duration_valid;
   assign sect_cmd.found = found;
   assign sect_cmd.key   = req_ff.section_key;
   assign sect_cmd.dur   = req_ff.duration;

   assign top_cmd.fire       = sect_cmd.fire
                               && (found || (sect_used_ff < SU_W'(SECTION_SLOTS)));
   assign top_cmd.entry.dur  = req_ff.duration;
   assign top_cmd.entry.key  = req_ff.section_key;
   assign top_cmd.entry.tick = req_ff.sample_tick;

   for (genvar i = 0; i < SECTION_SLOTS; i++) begin : g_sect
      assign sect_live[i] = sect_used_ff > SU_W'(i);
      assign sect_next[i] = sect_used_ff == SU_W'(i);
      lsst_sect_cell u_cell (
         .clock (clock),
         .cmd   (sect_cmd),
         .live  (sect_live[i]),
         .next  (sect_next[i]),
         .match (sect_match[i]),
         .entry (sect_entries[i])
      );
   end

   for (genvar j = 0; j < TOP_SLOTS; j++) begin : g_top
      assign top_live[j] = top_used_ff > TU_W'(j);
      if (j == 0) begin : g_head
         lsst_top_cell u_cell (
            .clock      (clock),
            .cmd        (top_cmd),
            .live       (top_live[j]),
            .prev_ge    (1'b1),
            .prev_entry (top_cmd.entry),
            .ge         (top_ge[j]),
            .entry      (top_entries[j])
         );
      end else begin : g_body
         lsst_top_cell u_cell (
            .clock      (clock),
            .cmd        (top_cmd),
            .live       (top_live[j]),
            .prev_ge    (top_ge[j-1]),
            .prev_entry (top_entries[j-1]),
            .ge         (top_ge[j]),
            .entry      (top_entries[j])
         );
      end
   end

   always_comb begin
      sect_rd    = '0;
      sect_rd_ok = 1'b0;
      for (int i = 0; i < SECTION_SLOTS; i++) begin
         if (sect_live[i] && (SSEL_W'(req_ff.slot_index) == SSEL_W'(i))) begin
            sect_rd    = sect_rd | sect_entries[i];
            sect_rd_ok = 1'b1;
         end
      end
   end

   always_comb begin
      top_rd    = '0;
      top_rd_ok = 1'b0;
      for (int j = 0; j < TOP_SLOTS; j++) begin
         if (top_live[j] && (TSEL_W'(req_ff.slot_index) == TSEL_W'(j))) begin
            top_rd    = top_rd | top_entries[j];
            top_rd_ok = 1'b1;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      sect_used_in   = sect_used_ff;
      top_used_in    = top_used_ff;
      sample_ctr_in  = sample_ctr_ff;
      drop_ctr_in    = drop_ctr_ff;
      invalid_ctr_in = invalid_ctr_ff;
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               unique case (mode)
                  lsst_pkg::MODE_RECORD: begin
                     if (!req_ff.duration_valid) begin
                        invalid_ctr_in = lsst_pkg::sat_inc(invalid_ctr_ff);
                        rsp_in.status  = lsst_pkg::STAT_INVALID;
                     end else begin
                        sample_ctr_in = lsst_pkg::sat_inc(sample_ctr_ff);
                        if (found) begin
                           rsp_in.status = lsst_pkg::STAT_EXISTING;
                        end else if (sect_used_ff < SU_W'(SECTION_SLOTS)) begin
                           rsp_in.status = lsst_pkg::STAT_NEW;
                           sect_used_in  = sect_used_ff + 1'b1;
                        end else begin
                           rsp_in.status = lsst_pkg::STAT_DROPPED;
                           drop_ctr_in   = lsst_pkg::sat_inc(drop_ctr_ff);
                        end
                        if (top_cmd.fire && (top_used_ff < TU_W'(TOP_SLOTS))) begin
                           top_used_in = top_used_ff + 1'b1;
                        end
                     end
                  end
                  lsst_pkg::MODE_READ_SECT: begin
                     rsp_in.status = lsst_pkg::STAT_READOUT;
                     if (sect_rd_ok) begin
                        rsp_in.entry_valid     = 1'b1;
                        rsp_in.entry_key       = sect_rd.key;
                        rsp_in.min_duration    = sect_rd.min;
                        rsp_in.max_duration    = sect_rd.max;
                        rsp_in.total_duration  = sect_rd.total;
                        rsp_in.section_samples = sect_rd.count;
                     end
                  end
                  lsst_pkg::MODE_READ_TOP: begin
                     rsp_in.status = lsst_pkg::STAT_READOUT;
                     if (top_rd_ok) begin
                        rsp_in.entry_valid  = 1'b1;
                        rsp_in.entry_key    = top_rd.key;
                        rsp_in.top_duration = top_rd.dur;
                        rsp_in.top_tick     = top_rd.tick;
                     end
                  end
                  lsst_pkg::MODE_CLEAR: begin
                     rsp_in.status          = lsst_pkg::STAT_READOUT;
                     rsp_in.total_samples   = sample_ctr_ff;
                     rsp_in.dropped_samples = drop_ctr_ff;
                     rsp_in.invalid_samples = invalid_ctr_ff;
                     sample_ctr_in  = '0;
                     drop_ctr_in    = '0;
                     invalid_ctr_in = '0;
                     sect_used_in   = '0;
                     top_used_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         sect_used_ff   <= '0;
         top_used_ff    <= '0;
         sample_ctr_ff  <= '0;
         drop_ctr_ff    <= '0;
         invalid_ctr_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         sect_used_ff   <= sect_used_in;
         top_used_ff    <= top_used_in;
         sample_ctr_ff  <= sample_ctr_in;
         drop_ctr_ff    <= drop_ctr_in;
         invalid_ctr_ff <= invalid_ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_ff.status;
   assign rsp_bus.entry_valid     = rsp_ff.entry_valid;
   assign rsp_bus.entry_key       = rsp_ff.entry_key;
   assign rsp_bus.min_duration    = rsp_ff.min_duration;
   assign rsp_bus.max_duration    = rsp_ff.max_duration;
   assign rsp_bus.total_duration  = rsp_ff.total_duration;
   assign rsp_bus.section_samples = rsp_ff.section_samples;
   assign rsp_bus.top_duration    = rsp_ff.top_duration;
   assign rsp_bus.top_tick        = rsp_ff.top_tick;
   assign rsp_bus.total_samples   = rsp_ff.total_samples;
   assign rsp_bus.dropped_samples = rsp_ff.dropped_samples;
   assign rsp_bus.invalid_samples = rsp_ff.invalid_samples;

endmodule

### bench/tb_latency_section_stats_topk.sv
module tb_latency_section_stats_topk;

   localparam int SECTION_SLOTS = 32;
   localparam int TOP_SLOTS     = 10;
   localparam int LIMIT         = 3000000;

   typedef struct {
      lsst_pkg::req_type w;
      bit                drain;
   } queued_word_type;

   typedef enum {
      RX_OPEN,
      RX_COIN,
      RX_THIRD,
      RX_MOSTLY
   } rx_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsst_req_if req_if ();
   lsst_rsp_if rsp_if ();

   latency_section_stats_topk #(
      .SECTION_SLOTS(SECTION_SLOTS),
      .TOP_SLOTS    (TOP_SLOTS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // section table, worst-sample list and window counters
   logic [lsst_pkg::KEY_W-1:0] sec_key [SECTION_SLOTS];
   logic [lsst_pkg::DUR_W-1:0] sec_lo  [SECTION_SLOTS];
   logic [lsst_pkg::DUR_W-1:0] sec_hi  [SECTION_SLOTS];
   logic [lsst_pkg::TOT_W-1:0] sec_sum [SECTION_SLOTS];
   logic [lsst_pkg::CNT_W-1:0] sec_n   [SECTION_SLOTS];
   int                         sec_fill = 0;

   logic [lsst_pkg::DUR_W-1:0]  worst_dur  [TOP_SLOTS];
   logic [lsst_pkg::KEY_W-1:0]  worst_key  [TOP_SLOTS];
   logic [lsst_pkg::TICK_W-1:0] worst_tick [TOP_SLOTS];
   int                          worst_fill = 0;

   logic [lsst_pkg::CNT_W-1:0] cnt_ok   = '0;
   logic [lsst_pkg::CNT_W-1:0] cnt_drop = '0;
   logic [lsst_pkg::CNT_W-1:0] cnt_bad  = '0;

   queued_word_type   word_backlog[$];
   lsst_pkg::rsp_type stats_answers[$];

   int n_total = 0;
   int n_sent  = 0;
   int n_got   = 0;
   int errors  = 0;
   int cycle_n = 0;

   int burst_left = 0;
   int gap_left   = 0;

   int             hold_left    = 0;
   int             next_hold_at = 50;
   int             phase_left   = 0;
   int             phase_tick   = 0;
   rx_pattern_type rx_mode      = RX_OPEN;

   function automatic logic [lsst_pkg::CNT_W-1:0] bump(input logic [lsst_pkg::CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic lsst_pkg::rsp_type stats_apply(input lsst_pkg::req_type w);
      lsst_pkg::rsp_type        r;
      int                       hit;
      int                       pos;
      logic [lsst_pkg::TOT_W:0] wide;
      r = '0;
      case (lsst_pkg::mode_type'(w.mode))
         lsst_pkg::MODE_RECORD: begin
            if (!w.duration_valid) begin
               cnt_bad  = bump(cnt_bad);
               r.status = lsst_pkg::STAT_INVALID;
            end else begin
               cnt_ok = bump(cnt_ok);
               hit = -1;
               for (int i = 0; i < sec_fill; i++)
                  if (hit < 0 && sec_key[i] == w.section_key) hit = i;
               if (hit >= 0) begin
                  if (w.duration < sec_lo[hit]) sec_lo[hit] = w.duration;
                  if (w.duration > sec_hi[hit]) sec_hi[hit] = w.duration;
                  wide = {1'b0, sec_sum[hit]} + (lsst_pkg::TOT_W+1)'(w.duration);
                  sec_sum[hit] = wide[lsst_pkg::TOT_W] ? '1 : wide[lsst_pkg::TOT_W-1:0];
                  sec_n[hit]   = bump(sec_n[hit]);
                  r.status     = lsst_pkg::STAT_EXISTING;
               end else if (sec_fill < SECTION_SLOTS) begin
                  sec_key[sec_fill] = w.section_key;
                  sec_lo[sec_fill]  = w.duration;
                  sec_hi[sec_fill]  = w.duration;
                  sec_sum[sec_fill] = lsst_pkg::TOT_W'(w.duration);
                  sec_n[sec_fill]   = 1;
                  sec_fill++;
                  r.status = lsst_pkg::STAT_NEW;
               end else begin
                  cnt_drop = bump(cnt_drop);
                  r.status = lsst_pkg::STAT_DROPPED;
               end
               if (r.status != lsst_pkg::STAT_DROPPED) begin
                  if (worst_fill < TOP_SLOTS) begin
                     pos = worst_fill;
                     worst_fill++;
                  end else if (w.duration > worst_dur[TOP_SLOTS-1]) begin
                     pos = TOP_SLOTS - 1;
                  end else begin
                     pos = -1;
                  end
                  if (pos >= 0) begin
                     while (pos > 0 && w.duration > worst_dur[pos-1]) begin
                        worst_dur[pos]  = worst_dur[pos-1];
                        worst_key[pos]  = worst_key[pos-1];
                        worst_tick[pos] = worst_tick[pos-1];
                        pos--;
                     end
                     worst_dur[pos]  = w.duration;
                     worst_key[pos]  = w.section_key;
                     worst_tick[pos] = w.sample_tick;
                  end
               end
            end
         end
         lsst_pkg::MODE_READ_SECT: begin
            r.status = lsst_pkg::STAT_READOUT;
            if (int'(w.slot_index) < sec_fill) begin
               r.entry_valid     = 1'b1;
               r.entry_key       = sec_key[w.slot_index];
               r.min_duration    = sec_lo[w.slot_index];
               r.max_duration    = sec_hi[w.slot_index];
               r.total_duration  = sec_sum[w.slot_index];
               r.section_samples = sec_n[w.slot_index];
            end
         end
         lsst_pkg::MODE_READ_TOP: begin
            r.status = lsst_pkg::STAT_READOUT;
            if (int'(w.slot_index) < worst_fill) begin
               r.entry_valid  = 1'b1;
               r.entry_key    = worst_key[w.slot_index];
               r.top_duration = worst_dur[w.slot_index];
               r.top_tick     = worst_tick[w.slot_index];
            end
         end
         default: begin
            r.status          = lsst_pkg::STAT_READOUT;
            r.total_samples   = cnt_ok;
            r.dropped_samples = cnt_drop;
            r.invalid_samples = cnt_bad;
            cnt_ok     = '0;
            cnt_drop   = '0;
            cnt_bad    = '0;
            sec_fill   = 0;
            worst_fill = 0;
         end
      endcase
      return r;
   endfunction

   function automatic lsst_pkg::req_type record_word(
         input logic [lsst_pkg::KEY_W-1:0] key,
         input logic [lsst_pkg::DUR_W-1:0] dur,
         input logic ok,
         input logic [lsst_pkg::TICK_W-1:0] tick);
      lsst_pkg::req_type w;
      w.mode           = lsst_pkg::MODE_RECORD;
      w.section_key    = key;
      w.duration       = dur;
      w.duration_valid = ok;
      w.sample_tick    = tick;
      w.slot_index     = lsst_pkg::SLOT_W'($urandom);
      return w;
   endfunction

   function automatic lsst_pkg::req_type query_word(input lsst_pkg::mode_type m,
                                                    input logic [lsst_pkg::SLOT_W-1:0] slot);
      lsst_pkg::req_type w;
      w.mode           = m;
      w.section_key    = lsst_pkg::KEY_W'($urandom);
      w.duration       = lsst_pkg::DUR_W'($urandom);
      w.duration_valid = 1'($urandom);
      w.sample_tick    = lsst_pkg::TICK_W'($urandom);
      w.slot_index     = slot;
      return w;
   endfunction

   function automatic logic [lsst_pkg::DUR_W-1:0] random_dur();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1000);
         2: return $urandom_range(0, 3) * 100;
         default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
   endfunction

   task automatic queue_word(input lsst_pkg::req_type w, input bit drain);
      queued_word_type q;
      q.w     = w;
      q.drain = drain;
      word_backlog.push_back(q);
      n_total++;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t %s expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n == LIMIT) begin
         $display("latency_section_stats_topk verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      int                acc;
      lsst_pkg::req_type w;
      queued_word_type   nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         acc = (req_if.valid && req_if.ready) ? 1 : 0;
         if (acc != 0) begin
            w.mode           = req_if.mode;
            w.section_key    = req_if.section_key;
            w.duration       = req_if.duration;
            w.duration_valid = req_if.duration_valid;
            w.sample_tick    = req_if.sample_tick;
            w.slot_index     = req_if.slot_index;
            stats_answers.push_back(stats_apply(w));
         end
         n_sent <= n_sent + acc;
         if (req_if.valid && !req_if.ready) begin
            // hold the word until taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (word_backlog.size() > 0 &&
                      (!word_backlog[0].drain || n_sent + acc == n_got)) begin
            nxt = word_backlog.pop_front();
            req_if.mode           <= nxt.w.mode;
            req_if.section_key    <= nxt.w.section_key;
            req_if.duration       <= nxt.w.duration;
            req_if.duration_valid <= nxt.w.duration_valid;
            req_if.sample_tick    <= nxt.w.sample_tick;
            req_if.slot_index     <= nxt.w.slot_index;
            req_if.valid          <= 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(1, 32);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      lsst_pkg::rsp_type got;
      lsst_pkg::rsp_type want;
      logic              rdy;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.status          = rsp_if.status;
            got.entry_valid     = rsp_if.entry_valid;
            got.entry_key       = rsp_if.entry_key;
            got.min_duration    = rsp_if.min_duration;
            got.max_duration    = rsp_if.max_duration;
            got.total_duration  = rsp_if.total_duration;
            got.section_samples = rsp_if.section_samples;
            got.top_duration    = rsp_if.top_duration;
            got.top_tick        = rsp_if.top_tick;
            got.total_samples   = rsp_if.total_samples;
            got.dropped_samples = rsp_if.dropped_samples;
            got.invalid_samples = rsp_if.invalid_samples;
            if (stats_answers.size() == 0) begin
               errors++;
               $display("%0t unrequested word expected none actual status %0h",
                        $time, got.status);
            end else begin
               want = stats_answers.pop_front();
               check_field("status", 64'(want.status), 64'(got.status));
               check_field("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
               check_field("entry_key", 64'(want.entry_key), 64'(got.entry_key));
               check_field("min_duration", 64'(want.min_duration),
                           64'(got.min_duration));
               check_field("max_duration", 64'(want.max_duration),
                           64'(got.max_duration));
               check_field("total_duration", 64'(want.total_duration),
                           64'(got.total_duration));
               check_field("section_samples", 64'(want.section_samples),
                           64'(got.section_samples));
               check_field("top_duration", 64'(want.top_duration),
                           64'(got.top_duration));
               check_field("top_tick", 64'(want.top_tick), 64'(got.top_tick));
               check_field("total_samples", 64'(want.total_samples),
                           64'(got.total_samples));
               check_field("dropped_samples", 64'(want.dropped_samples),
                           64'(got.dropped_samples));
               check_field("invalid_samples", 64'(want.invalid_samples),
                           64'(got.invalid_samples));
            end
            n_got <= n_got + 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (n_got >= next_hold_at) begin
            hold_left    = 300;
            next_hold_at = next_hold_at + 4000;
            rdy          = 1'b0;
         end else begin
            if (phase_left == 0) begin
               case ($urandom_range(0, 5))
                  0, 1, 2: rx_mode = RX_OPEN;
                  3:       rx_mode = RX_COIN;
                  4:       rx_mode = RX_THIRD;
                  default: rx_mode = RX_MOSTLY;
               endcase
               phase_left = $urandom_range(30, 200);
            end
            phase_left--;
            phase_tick++;
            case (rx_mode)
               RX_OPEN:  rdy = 1'b1;
               RX_COIN:  rdy = 1'($urandom_range(0, 1));
               RX_THIRD: rdy = (phase_tick % 3 == 0);
               default:  rdy = ($urandom_range(0, 6) != 0);
            endcase
         end
         rsp_if.ready <= rdy;
      end
   end

   initial begin
      logic [lsst_pkg::KEY_W-1:0] pool [48];
      int                         pool_n;
      int                         recs;
      int                         r;
      int                         rand_items;
      bit                         big;
      logic [lsst_pkg::KEY_W-1:0] k;
      lsst_pkg::req_type          w;

      req_if.valid          = 1'b0;
      req_if.mode           = '0;
      req_if.section_key    = '0;
      req_if.duration       = '0;
      req_if.duration_valid = 1'b0;
      req_if.sample_tick    = '0;
      req_if.slot_index     = '0;
      rsp_if.ready          = 1'b0;

      // empty tables, empty counters, extremes, ties
      queue_word(query_word(lsst_pkg::MODE_READ_SECT, 5'd0), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_READ_TOP, 5'd31), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_CLEAR, 5'd0), 1'b0);
      queue_word(record_word(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF), 1'b0);
      queue_word(record_word(16'h0000, 32'h0, 1'b1, 32'h0), 1'b0);
      queue_word(record_word(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF), 1'b0);
      queue_word(record_word(16'h0000, 32'hFFFF_FFFF, 1'b1, 32'h1), 1'b0);
      queue_word(record_word(16'hFFFF, 32'h0, 1'b1, 32'h2), 1'b0);
      queue_word(record_word(16'h0005, 32'd7, 1'b1, 32'h3), 1'b0);
      queue_word(record_word(16'h0006, 32'd7, 1'b1, 32'h4), 1'b0);
      queue_word(record_word(16'h0005, 32'd7, 1'b0, 32'h5), 1'b0);
      for (int s = 0; s < 7; s++)
         queue_word(query_word(lsst_pkg::MODE_READ_TOP, lsst_pkg::SLOT_W'(s)), 1'b0);
      for (int s = 0; s < 4; s++)
         queue_word(query_word(lsst_pkg::MODE_READ_SECT, lsst_pkg::SLOT_W'(s)), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_READ_SECT, 5'd31), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_CLEAR, 5'd31), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_READ_SECT, 5'd0), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_READ_TOP, 5'd0), 1'b0);

      rand_items = 0;
      while (rand_items < 350) begin
         big = ($urandom_range(0, 3) == 0);
         pool_n = big ? $urandom_range(30, 45) : $urandom_range(1, 12);
         for (int i = 0; i < pool_n; i++) pool[i] = lsst_pkg::KEY_W'($urandom);
         recs = big ? pool_n + $urandom_range(5, 20) : $urandom_range(5, 60);
         for (int j = 0; j < recs; j++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
               k = (big && j < pool_n) ? pool[j] : pool[$urandom_range(0, pool_n - 1)];
               w = record_word(k, random_dur(), $urandom_range(0, 9) != 0,
                               lsst_pkg::TICK_W'($urandom));
            end else if (r < 85) begin
               w = query_word(lsst_pkg::MODE_READ_SECT, lsst_pkg::SLOT_W'($urandom));
            end else if (r < 95) begin
               w = query_word(lsst_pkg::MODE_READ_TOP,
                              lsst_pkg::SLOT_W'($urandom_range(0, 1) ? $urandom_range(0, 11)
                                                                   : $urandom_range(0, 31)));
            end else begin
               w.mode           = lsst_pkg::MODE_W'($urandom);
               w.section_key    = lsst_pkg::KEY_W'($urandom);
               w.duration       = lsst_pkg::DUR_W'($urandom);
               w.duration_valid = 1'($urandom);
               w.sample_tick    = lsst_pkg::TICK_W'($urandom);
               w.slot_index     = lsst_pkg::SLOT_W'($urandom);
            end
            queue_word(w, j == 0 && $urandom_range(0, 3) == 0);
            rand_items++;
         end
         for (int s = 0; s < 3; s++) begin
            queue_word(query_word(lsst_pkg::MODE_READ_SECT,
                                  lsst_pkg::SLOT_W'($urandom_range(0, 1) ? s : $urandom)),
                       1'b0);
            queue_word(query_word(lsst_pkg::MODE_READ_TOP,
                                  lsst_pkg::SLOT_W'($urandom_range(0, TOP_SLOTS))), 1'b0);
            rand_items += 2;
         end
         queue_word(query_word(lsst_pkg::MODE_CLEAR, lsst_pkg::SLOT_W'($urandom)), 1'b0);
         rand_items++;
      end

      // wait for an empty pipe, then fill the top list with equal maxima
      queue_word(query_word(lsst_pkg::MODE_CLEAR, lsst_pkg::SLOT_W'($urandom)), 1'b1);
      for (int j = 0; j < 12; j++)
         queue_word(record_word(lsst_pkg::KEY_W'(j % 3), 32'hFFFF_FFFF, 1'b1,
                                lsst_pkg::TICK_W'($urandom)), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_READ_SECT, 5'd0), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_READ_TOP, 5'd0), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_READ_TOP, lsst_pkg::SLOT_W'(TOP_SLOTS - 1)), 1'b0);
      queue_word(query_word(lsst_pkg::MODE_CLEAR, lsst_pkg::SLOT_W'($urandom)), 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (n_got < n_total) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0 && stats_answers.size() == 0) begin
         $display("latency_section_stats_topk verification clean");
      end else begin
         $display("latency_section_stats_topk verification failed");
      end
      $finish;
   end

endmodule
